### hdl/wmf_pkg.sv
// Shared types and fixed constants of the window majority filter.
package wmf_pkg;

    // Fixed field widths.
    localparam int PIXEL_W = 8;
    localparam int CFG_W   = 11;

    // Line width after reset.
    localparam logic [CFG_W-1:0] LINE_WIDTH_RESET = 11'd720;

    // Control that the pipeline hands to the summing unit with each window column.
    typedef struct packed {
        logic advance;
        logic win_valid;
    } t_s1_ctl;

endpackage

### hdl/wmf_if.sv
// Handshake interfaces for the pixel input and the filter result channels.
interface wmf_pixel_if;
    logic                        valid;
    logic                        ready;
    logic [wmf_pkg::PIXEL_W-1:0] pixel;
    logic                        frame_start;

    modport source (output valid, output pixel, output frame_start, input ready);
    modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

interface wmf_result_if;
    logic valid;
    logic ready;
    logic majority;
    logic window_valid;

    modport source (output valid, output majority, output window_valid, input ready);
    modport sink   (input valid, input majority, input window_valid, output ready);
endinterface

### hdl/wmf_line_mem.sv
// Line store memory with a registered read port, write-to-read bypass and a fill count.
module wmf_line_mem #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    output logic [WIDTH-1:0]         o_rd_data
);

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;
    logic [WIDTH-1:0] r_byp_data;
    logic             r_byp;
    logic             r_blank;
    logic [AW:0]      r_fill;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_q        <= r_mem[i_rd_addr];
            r_byp_data <= i_wr_data;
        end
    end

    // A read that meets a write to the same entry returns the new data. Entries are first
    // written in ascending order, so everything below the fill count holds data and
    // everything at or above it reads as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp   <= 1'b0;
            r_blank <= 1'b0;
            r_fill  <= '0;
        end else begin
            if (i_rd_en) begin
                r_byp   <= i_wr_en && (i_wr_addr == i_rd_addr);
                r_blank <= {1'b0, i_rd_addr} >= r_fill;
            end
            if (i_wr_en && ({1'b0, i_wr_addr} == r_fill)) begin
                r_fill <= r_fill + (AW + 1)'(1);
            end
        end
    end

    assign o_rd_data = r_byp ? r_byp_data : (r_blank ? '0 : r_q);

endmodule

### hdl/wmf_scan.sv
// Column and row position tracking of the raster scan.
module wmf_scan #(
    parameter int WINDOW    = 3,
    parameter int MAX_WIDTH = 1024
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  logic                         i_frame_start,
    input  logic [wmf_pkg::CFG_W-1:0]    i_line_width,
    output logic [$clog2(MAX_WIDTH)-1:0] o_col,
    output logic                         o_win_valid
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(WINDOW);
    localparam int EW = (AW + 1 > wmf_pkg::CFG_W) ? AW + 1 : wmf_pkg::CFG_W;

    logic [AW-1:0] r_col;
    logic [AW-1:0] n_col;
    logic [RW-1:0] r_row;
    logic [RW-1:0] n_row;
    logic [AW-1:0] cur_col;
    logic [RW-1:0] cur_row;
    logic [EW-1:0] width_eff;
    logic [EW-1:0] col_inc;

    always_comb begin
        cur_col = i_frame_start ? '0 : r_col;
        cur_row = i_frame_start ? '0 : r_row;

        // A width of zero acts as one; widths beyond the store are clamped.
        if (i_line_width == '0) begin
            width_eff = EW'(1);
        end else if (EW'(i_line_width) > EW'(MAX_WIDTH)) begin
            width_eff = EW'(MAX_WIDTH);
        end else begin
            width_eff = EW'(i_line_width);
        end

        col_inc = EW'(cur_col) + EW'(1);
        n_row   = cur_row;
        if (col_inc >= width_eff) begin
            n_col = '0;
            if (cur_row < RW'(WINDOW - 1)) begin
                n_row = cur_row + RW'(1);
            end
        end else begin
            n_col = col_inc[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    assign o_col       = cur_col;
    assign o_win_valid = (cur_col >= AW'(WINDOW - 1)) && (cur_row >= RW'(WINDOW - 1));

endmodule

### hdl/wmf_sum.sv
// Column sums, running window sum and the majority decision.
module wmf_sum #(
    parameter int WINDOW = 3
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  wmf_pkg::t_s1_ctl                             i_ctl,
    input  logic [(WINDOW-1)*wmf_pkg::PIXEL_W-1:0]       i_rows,
    input  logic [wmf_pkg::PIXEL_W-1:0]                  i_pixel,
    output logic                                         o_majority
);

    localparam int LINES = WINDOW - 1;
    localparam int AREA  = WINDOW * WINDOW;
    localparam int CSW   = $clog2(WINDOW * 255 + 1);
    localparam int SW    = $clog2(AREA * 255 + 1);

    logic [CSW-1:0] r_cs [WINDOW];
    logic [SW-1:0]  r_sum;
    logic [CSW-1:0] new_col;
    logic [SW-1:0]  n_sum;

    always_comb begin
        new_col = CSW'(i_pixel);
        for (int r = 0; r < LINES; r++) begin
            new_col = new_col + CSW'(i_rows[r*wmf_pkg::PIXEL_W +: wmf_pkg::PIXEL_W]);
        end
        // The oldest column leaves the window and the new one enters.
        n_sum = r_sum - SW'(r_cs[0]) + SW'(new_col);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            for (int c = 0; c < WINDOW; c++) begin
                r_cs[c] <= '0;
            end
        end else if (i_ctl.advance) begin
            r_sum <= n_sum;
            for (int c = 0; c < WINDOW - 1; c++) begin
                r_cs[c] <= r_cs[c+1];
            end
            r_cs[WINDOW-1] <= new_col;
        end
    end

    assign o_majority = i_ctl.win_valid && ({n_sum, 1'b0} > (SW + 1)'(AREA));

endmodule

### hdl/window_majority_filter.sv
// Top level of the streaming window majority filter.
// The filter takes one pixel per clock in raster order while results drain and returns
// one result per pixel: the majority over the WINDOW x WINDOW window whose bottom-right
// corner is that pixel, together with a flag that says whether the window lies wholly
// inside the frame. Outside the frame the majority bit is zero. A pixel with frame_start
// set becomes column 0 of row 0; the frame height is never configured. Throughput is one
// transaction per clock while results drain. The accepting edge loads the registered
// read of the line store at the pixel's column, and the edge on which the second stage
// advances updates the column sums and fills the output register. The line store holds
// WINDOW-1 lines in one memory word per column and is rewritten in place on that edge;
// when the next pixel reads that column in the same cycle, the new word is forwarded to
// it. Columns not yet written since reset read as zero, which a fill count in the line
// store tracks, so no clearing pass is needed after reset. Write line_width only while
// the filter is idle; zero acts as one, and values above MAX_WIDTH act as MAX_WIDTH.
module window_majority_filter #(
    parameter int WINDOW    = 3,
    parameter int MAX_WIDTH = 1024
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    wmf_pixel_if.sink                 i_pix,
    wmf_result_if.source              o_res,
    input  logic                      i_cfg_wr_en,
    input  logic [wmf_pkg::CFG_W-1:0] i_cfg_wr_data
);

    localparam int AW    = $clog2(MAX_WIDTH);
    localparam int LINES = WINDOW - 1;
    localparam int LW    = LINES * wmf_pkg::PIXEL_W;

    logic [wmf_pkg::CFG_W-1:0]   r_line_width;

    // Second stage: the pixel whose line store word is being read.
    logic                        r_s1_valid;
    logic                        n_s1_valid;
    logic [wmf_pkg::PIXEL_W-1:0] r_s1_px;
    logic                        r_s1_wvalid;
    logic [AW-1:0]               r_s1_col;

    // Output register.
    logic                        r_out_valid;
    logic                        n_out_valid;
    logic                        r_out_maj;
    logic                        r_out_wvalid;

    logic                        accept;
    logic                        s1_free;
    logic                        s1_go;
    logic [AW-1:0]               scan_col;
    logic                        scan_win_valid;
    logic [LW-1:0]               rows;
    logic [LW-1:0]               wr_word;
    logic                        maj;
    wmf_pkg::t_s1_ctl            s1_ctl;

    // The output register frees the second stage whenever it is empty or being drained.
    assign s1_free     = !r_out_valid || o_res.ready;
    assign s1_go       = r_s1_valid && s1_free;
    assign i_pix.ready = !r_s1_valid || s1_free;
    assign accept      = i_pix.valid && i_pix.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= wmf_pkg::LINE_WIDTH_RESET;
        end else if (i_cfg_wr_en) begin
            r_line_width <= i_cfg_wr_data;
        end
    end

    wmf_scan #(
        .WINDOW    (WINDOW),
        .MAX_WIDTH (MAX_WIDTH)
    ) u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_frame_start (i_pix.frame_start),
        .i_line_width  (r_line_width),
        .o_col         (scan_col),
        .o_win_valid   (scan_win_valid)
    );

    // Each line moves up one row in this column and the new pixel enters at the bottom.
    assign wr_word = {r_s1_px, rows[LW-1:wmf_pkg::PIXEL_W]};

    wmf_line_mem #(
        .DEPTH (MAX_WIDTH),
        .WIDTH (LW)
    ) u_line_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_addr (scan_col),
        .i_wr_en   (s1_go),
        .i_wr_addr (r_s1_col),
        .i_wr_data (wr_word),
        .o_rd_data (rows)
    );

    assign s1_ctl.advance   = s1_go;
    assign s1_ctl.win_valid = r_s1_wvalid;

    wmf_sum #(
        .WINDOW (WINDOW)
    ) u_sum (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (s1_ctl),
        .i_rows     (rows),
        .i_pixel    (r_s1_px),
        .o_majority (maj)
    );

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (accept) begin
            n_s1_valid = 1'b1;
        end else if (s1_go) begin
            n_s1_valid = 1'b0;
        end

        n_out_valid = r_out_valid;
        if (s1_go) begin
            n_out_valid = 1'b1;
        end else if (o_res.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_px     <= i_pix.pixel;
            r_s1_wvalid <= scan_win_valid;
            r_s1_col    <= scan_col;
        end
        if (s1_go) begin
            r_out_maj    <= maj;
            r_out_wvalid <= r_s1_wvalid;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.majority     = r_out_maj;
    assign o_res.window_valid = r_out_wvalid;

`ifndef NO_ASSERTIONS
    // Border results never report a majority.
    a_border_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_wvalid |-> !r_out_maj)
        else $error("majority set on a window outside the frame");

    // An accepted pixel always occupies the second stage in the next cycle.
    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_s1_valid)
        else $error("accepted pixel lost before the line store update");

    // A stalled second stage keeps its write address until the write happens.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s1_free |=> r_s1_valid && $stable(r_s1_col))
        else $error("line store address changed while stalled");
`endif

endmodule
